// ----- src/fdlc_pkg.sv -----
// Shared types, constants and helpers for the delimited frame letter counter.
package fdlc_pkg;

    // Field widths fixed by the interface
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 6;

    // Frame length limit and command queue size
    localparam int MAX_FRAME_LEN_DEF = 35;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_START_SYMBOL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_SYMBOL   = 1'd1;

    // Reset values of the delimiters ('#' and '$')
    localparam logic [BYTE_W-1:0] START_SYMBOL_RST = 8'd35;
    localparam logic [BYTE_W-1:0] END_SYMBOL_RST   = 8'd36;

    // ASCII letter bounds
    localparam logic [BYTE_W-1:0] LOWER_FIRST = 8'h61;
    localparam logic [BYTE_W-1:0] LOWER_LAST  = 8'h7A;
    localparam logic [BYTE_W-1:0] UPPER_FIRST = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_LAST  = 8'h5A;

    // Result kinds
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Commands from the front to the back
    typedef enum logic [1:0] {
        OP_STORE,
        OP_REPORT,
        OP_DROP
    } fdlc_op_t;

    typedef struct packed {
        fdlc_op_t          op;
        logic [BYTE_W-1:0] data;
    } fdlc_cmd_t;

    // One result item
    typedef struct packed {
        logic              item_kind;
        logic [BYTE_W-1:0] frame_byte;
        logic [CNT_W-1:0]  lower_total;
        logic [CNT_W-1:0]  upper_total;
        logic [CNT_W-1:0]  frame_length;
        logic              last_item;
    } fdlc_result_t;

    // Back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_SUMMARY
    } fdlc_state_t;

    function automatic logic is_lower(input logic [BYTE_W-1:0] b);
        return (b >= LOWER_FIRST) && (b <= LOWER_LAST);
    endfunction

    function automatic logic is_upper(input logic [BYTE_W-1:0] b);
        return (b >= UPPER_FIRST) && (b <= UPPER_LAST);
    endfunction

endpackage

// ----- src/fdlc_front.sv -----
// Front end: holds the delimiters, tracks the frame and classifies each byte.
module fdlc_front #(
    parameter int MAX_FRAME_LEN = fdlc_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [fdlc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fdlc_pkg::BYTE_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fdlc_pkg::BYTE_W-1:0]   s_rx_byte,
    input  logic                          q_full,
    output logic                          q_push,
    output fdlc_pkg::fdlc_cmd_t           q_cmd
);
    import fdlc_pkg::*;

    logic [BYTE_W-1:0] start_sym_reg;
    logic [BYTE_W-1:0] end_sym_reg;
    logic              open_reg, open_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic              accept;
    logic              cmd_valid;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Write the delimiter registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_sym_reg <= START_SYMBOL_RST;
            end_sym_reg   <= END_SYMBOL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_START_SYMBOL: start_sym_reg <= cfg_wdata;
                REG_END_SYMBOL:   end_sym_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Classify the byte against the frame state
    always_comb begin
        open_next   = open_reg;
        len_next    = len_reg;
        cmd_valid   = 1'b0;
        q_cmd.op    = OP_STORE;
        q_cmd.data  = s_rx_byte;
        if (accept) begin
            if (open_reg) begin
                cmd_valid = 1'b1;
                if (s_rx_byte == end_sym_reg) begin
                    q_cmd.op  = OP_REPORT;
                    open_next = 1'b0;
                    len_next  = '0;
                end else if (len_reg >= CNT_W'(MAX_FRAME_LEN)) begin
                    q_cmd.op  = OP_DROP;
                    open_next = 1'b0;
                    len_next  = '0;
                end else begin
                    q_cmd.op  = OP_STORE;
                    len_next  = len_reg + 1'b1;
                end
            end
            if (s_rx_byte == start_sym_reg) begin
                open_next = 1'b1;
            end
        end
    end

    assign q_push = cmd_valid;

    // Hold the frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 1'b0;
            len_reg  <= '0;
        end else begin
            open_reg <= open_next;
            len_reg  <= len_next;
        end
    end

endmodule

// ----- src/fdlc_queue.sv -----
// Short command queue between the front and back ends.
module fdlc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  fdlc_pkg::fdlc_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output fdlc_pkg::fdlc_cmd_t head_cmd
);
    import fdlc_pkg::*;

    fdlc_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Store a pushed command
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ----- src/fdlc_back.sv -----
// Back end: frame store, letter counters and read-out sequencer.
module fdlc_back #(
    parameter int MAX_FRAME_LEN = fdlc_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cmd_valid,
    input  fdlc_pkg::fdlc_cmd_t    cmd,
    output logic                   cmd_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output fdlc_pkg::fdlc_result_t result
);
    import fdlc_pkg::*;

    localparam int MEM_AW = (MAX_FRAME_LEN > 1) ? $clog2(MAX_FRAME_LEN) : 1;

    logic [BYTE_W-1:0] store_mem [MAX_FRAME_LEN];
    logic [BYTE_W-1:0] rd_data_reg;

    fdlc_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  lower_reg;
    logic [CNT_W-1:0]  upper_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  idx_inc;
    fdlc_result_t      out_reg;
    logic              out_valid_reg;

    logic out_free;
    logic wr_en;
    logic rd_en;
    logic load_byte;
    logic load_sum;
    logic clear;
    logic start_report;

    assign out_free = !out_valid_reg || m_ready;
    assign idx_inc  = idx_reg + 1'b1;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && cmd.op == OP_REPORT) begin
                    state_next = (count_reg == '0) ? ST_SUMMARY : ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_LOAD;
            ST_LOAD: begin
                if (out_free) begin
                    state_next = (idx_inc == count_reg) ? ST_SUMMARY : ST_FETCH;
                end
            end
            ST_SUMMARY: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer
    always_comb begin
        cmd_pop      = (state_reg == ST_IDLE) && cmd_valid;
        wr_en        = cmd_pop && (cmd.op == OP_STORE);
        start_report = cmd_pop && (cmd.op == OP_REPORT);
        rd_en        = (state_reg == ST_FETCH);
        load_byte    = (state_reg == ST_LOAD) && out_free;
        load_sum     = (state_reg == ST_SUMMARY) && out_free;
        clear        = (cmd_pop && (cmd.op == OP_DROP)) || load_sum;
    end

    // Frame store: write on store, registered read during read-out
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[count_reg[MEM_AW-1:0]] <= cmd.data;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[idx_reg[MEM_AW-1:0]];
        end
    end

    // Sequencer state, counters and read index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            lower_reg <= '0;
            upper_reg <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (clear) begin
                count_reg <= '0;
                lower_reg <= '0;
                upper_reg <= '0;
            end else if (wr_en) begin
                count_reg <= count_reg + 1'b1;
                if (is_lower(cmd.data)) begin
                    lower_reg <= lower_reg + 1'b1;
                end else if (is_upper(cmd.data)) begin
                    upper_reg <= upper_reg + 1'b1;
                end
            end
            if (start_report) begin
                idx_reg <= '0;
            end else if (load_byte) begin
                idx_reg <= idx_inc;
            end
        end
    end

    // Output register: load a byte or the summary, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_byte || load_sum) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_byte) begin
            out_reg.item_kind    <= KIND_BYTE;
            out_reg.frame_byte   <= rd_data_reg;
            out_reg.lower_total  <= '0;
            out_reg.upper_total  <= '0;
            out_reg.frame_length <= '0;
            out_reg.last_item    <= 1'b0;
        end else if (load_sum) begin
            out_reg.item_kind    <= KIND_SUMMARY;
            out_reg.frame_byte   <= '0;
            out_reg.lower_total  <= lower_reg;
            out_reg.upper_total  <= upper_reg;
            out_reg.frame_length <= count_reg;
            out_reg.last_item    <= 1'b1;
        end
    end

    assign m_valid = out_valid_reg;
    assign result  = out_reg;

endmodule

// ----- src/delimited_frame_letter_counter_top.sv -----
// Top level of the delimited frame letter counter.
//
// Usage: received bytes enter on the s_ channel (valid/ready). A start symbol
// opens a frame; bytes up to the end symbol are stored and their ASCII letters
// counted. On the end symbol the m_ channel delivers each stored byte in order
// (item_kind 0), then one summary item (item_kind 1, last_item 1) with the
// lower-case and upper-case counts and the frame length. A frame that grows
// past MAX_FRAME_LEN bytes is dropped without output. Delimiters are written
// through cfg_wr_en/cfg_index/cfg_wdata, which the user must do only while
// the block is idle; the block itself does not enforce this. Throughput: one
// byte per cycle while a frame fills and the command queue has room; the
// front end hands each byte of an open frame to a four-entry command queue.
// Read-out of a closed frame takes the report from the queue, then for each
// stored byte reads the frame store and then loads the output register, and
// last loads the summary. The queue fills during read-out and s_ready then
// drops.
// Reset (aresetn low, synchronous) restores '#' and '$', closes any frame and
// empties the queue and output register. If the receiver holds m_ready low,
// the output register holds its item and read-out waits.
module delimited_frame_letter_counter_top #(
    parameter int MAX_FRAME_LEN = fdlc_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [fdlc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fdlc_pkg::BYTE_W-1:0]    cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [fdlc_pkg::BYTE_W-1:0]    s_rx_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_item_kind,
    output logic [fdlc_pkg::BYTE_W-1:0]    m_frame_byte,
    output logic [fdlc_pkg::CNT_W-1:0]     m_lower_total,
    output logic [fdlc_pkg::CNT_W-1:0]     m_upper_total,
    output logic [fdlc_pkg::CNT_W-1:0]     m_frame_length,
    output logic                           m_last_item
);
    import fdlc_pkg::*;

    logic         q_full;
    logic         q_push;
    fdlc_cmd_t    q_cmd;
    logic         q_pop;
    logic         q_not_empty;
    fdlc_cmd_t    q_head;
    fdlc_result_t result;

    fdlc_front #(
        .MAX_FRAME_LEN(MAX_FRAME_LEN)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    fdlc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (q_head)
    );

    fdlc_back #(
        .MAX_FRAME_LEN(MAX_FRAME_LEN)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_not_empty),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .result    (result)
    );

    // Unpack the result item onto its ports
    assign m_item_kind    = result.item_kind;
    assign m_frame_byte   = result.frame_byte;
    assign m_lower_total  = result.lower_total;
    assign m_upper_total  = result.upper_total;
    assign m_frame_length = result.frame_length;
    assign m_last_item    = result.last_item;

endmodule

// ----- bench/delimited_frame_letter_counter_top_tb.sv -----
// Self-checking testbench for the delimited frame letter counter top level.
module delimited_frame_letter_counter_top_tb;
    import fdlc_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 9;
    localparam int IDLE_PCT       = 14;
    localparam int HOLD_CYCLES    = 120;
    localparam int SETTLE_CYCLES  = 2 * QUEUE_DEPTH + 8;
    localparam int PHASE_ITEMS    = 5;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int PRINT_CAP      = 50;

    // How a directed row is checked: by the predictor, or by a typed expectation
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_EMPTY
    } row_chk_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        row_chk_t          chk;
    } dir_row_t;

    localparam int DIR_ROWS = 19;
    // Directed bytes under the reset delimiters ('#' opens, '$' closes)
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{8'h00, CHK_NONE},   // lowest byte while closed: ignored
        '{8'hFF, CHK_NONE},   // highest byte while closed: ignored
        '{8'h24, CHK_NONE},   // end symbol while closed: ignored
        '{8'h61, CHK_NONE},   // letter while closed: ignored
        '{8'h23, CHK_NONE},   // open
        '{8'h24, CHK_EMPTY},  // empty frame: summary only, all counts zero
        '{8'h23, CHK_NONE},   // open again
        '{8'h61, CHK_MODEL},  // 'a'
        '{8'h7A, CHK_MODEL},  // 'z'
        '{8'h41, CHK_MODEL},  // 'A'
        '{8'h5A, CHK_MODEL},  // 'Z'
        '{8'h60, CHK_MODEL},  // just below 'a'
        '{8'h7B, CHK_MODEL},  // just above 'z'
        '{8'h40, CHK_MODEL},  // just below 'A'
        '{8'h5B, CHK_MODEL},  // just above 'Z'
        '{8'h23, CHK_MODEL},  // start symbol inside a frame is stored
        '{8'h00, CHK_MODEL},
        '{8'hFF, CHK_MODEL},
        '{8'h24, CHK_MODEL}   // close and report
    };

    localparam fdlc_result_t EMPTY_SUMMARY =
        '{item_kind: KIND_SUMMARY, last_item: 1'b1, default: '0};

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_rx_byte = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 m_item_kind;
    logic [BYTE_W-1:0]    m_frame_byte;
    logic [CNT_W-1:0]     m_lower_total;
    logic [CNT_W-1:0]     m_upper_total;
    logic [CNT_W-1:0]     m_frame_length;
    logic                 m_last_item;

    // Frame tracker state and delimiter copy
    logic              fr_open  = 1'b0;
    logic [CNT_W-1:0]  fr_len   = '0;
    logic [CNT_W-1:0]  fr_lower = '0;
    logic [CNT_W-1:0]  fr_upper = '0;
    logic [BYTE_W-1:0] fr_store [MAX_FRAME_LEN_DEF];
    logic [BYTE_W-1:0] sym_start = START_SYMBOL_RST;
    logic [BYTE_W-1:0] sym_end   = END_SYMBOL_RST;

    fdlc_result_t pending_items [$];

    bit typed_row  = 1'b0;
    bit no_idle    = 1'b0;
    bit hold_armed = 1'b0;
    int mismatches      = 0;
    int results_checked = 0;
    int frames_reported = 0;
    int frames_dropped  = 0;
    int bytes_fed       = 0;
    int holds_done      = 0;

    delimited_frame_letter_counter_top #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN_DEF)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item_kind    (m_item_kind),
        .m_frame_byte   (m_frame_byte),
        .m_lower_total  (m_lower_total),
        .m_upper_total  (m_upper_total),
        .m_frame_length (m_frame_length),
        .m_last_item    (m_last_item)
    );

    // Clock
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("mismatch at result %0d: %s", results_checked, msg);
        end
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // Advance the frame tracker by one accepted byte and queue what it reports
    task automatic track_rx_byte(input logic [BYTE_W-1:0] b);
        fdlc_result_t r;
        if (fr_open || b == sym_start) begin
            bytes_fed++;
        end
        if (fr_open) begin
            if (b == sym_end) begin
                for (int i = 0; i < int'(fr_len); i++) begin
                    r            = '0;
                    r.item_kind  = KIND_BYTE;
                    r.frame_byte = fr_store[i];
                    if (!typed_row) pending_items.push_back(r);
                end
                r              = '0;
                r.item_kind    = KIND_SUMMARY;
                r.lower_total  = fr_lower;
                r.upper_total  = fr_upper;
                r.frame_length = fr_len;
                r.last_item    = 1'b1;
                if (!typed_row) pending_items.push_back(r);
                frames_reported++;
                {fr_open, fr_len, fr_lower, fr_upper} = '0;
            end else if (int'(fr_len) >= MAX_FRAME_LEN_DEF) begin
                // drop the frame silently, the overflowing byte is not kept
                {fr_open, fr_len, fr_lower, fr_upper} = '0;
                frames_dropped++;
            end else begin
                if (b >= LOWER_FIRST && b <= LOWER_LAST) begin
                    fr_lower++;
                end else if (b >= UPPER_FIRST && b <= UPPER_LAST) begin
                    fr_upper++;
                end
                fr_store[fr_len] = b;
                fr_len++;
            end
        end
        if (b == sym_start) begin
            fr_open = 1'b1;
        end
    endtask

    // Offer one byte, idling now and then; return at the falling edge after acceptance
    task automatic push_rx(input logic [BYTE_W-1:0] b);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        track_rx_byte(b);
        @(negedge aclk);
    endtask

    // Frame content, biased to letters, never the end symbol
    function automatic logic [BYTE_W-1:0] rand_content();
        logic [BYTE_W-1:0] b;
        do begin
            case ($urandom_range(3))
                0:       b = LOWER_FIRST + BYTE_W'($urandom_range(25));
                1:       b = UPPER_FIRST + BYTE_W'($urandom_range(25));
                default: b = BYTE_W'($urandom_range(255));
            endcase
        end while (b == sym_end);
        return b;
    endfunction

    // Mostly well-formed frames of random content, some noise and unclosed frames
    task automatic send_random_frames(input int items);
        int stop_at;
        int pick;
        int len;
        stop_at = bytes_fed + items;
        while (bytes_fed < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                repeat ($urandom_range(4, 1)) push_rx(BYTE_W'($urandom_range(255)));
            end else begin
                if (pick < 90) begin
                    len = $urandom_range(8);
                end else if (pick < 96) begin
                    len = $urandom_range(MAX_FRAME_LEN_DEF, 9);
                end else begin
                    len = $urandom_range(MAX_FRAME_LEN_DEF + 3, MAX_FRAME_LEN_DEF + 1);
                end
                push_rx(sym_start);
                repeat (len) push_rx(rand_content());
                if ($urandom_range(99) >= 8) begin
                    push_rx(sym_end);
                end
            end
        end
    endtask

    // Drop valid, wait for every expected item, then let the command queue empty
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_items.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_symbols(input logic [BYTE_W-1:0] start_b,
                               input logic [BYTE_W-1:0] end_b);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_START_SYMBOL;
        cfg_wdata <= start_b;
        @(negedge aclk);
        cfg_index <= REG_END_SYMBOL;
        cfg_wdata <= end_b;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sym_start = start_b;
        sym_end   = end_b;
    endtask

    // Result receiver: random back-pressure, and one long hold-off when armed
    initial begin : drive_ready
        forever begin
            @(negedge aclk);
            if (hold_armed && m_valid) begin
                hold_armed = 1'b0;
                holds_done++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare each accepted result with the oldest pending expectation
    always @(posedge aclk) begin : check_results
        fdlc_result_t got;
        fdlc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_item_kind, m_frame_byte, m_lower_total, m_upper_total,
                    m_frame_length, m_last_item};
            if (pending_items.size() == 0) begin
                report_mismatch($sformatf("item kind %0d byte %0d with nothing pending",
                                          got.item_kind, got.frame_byte));
            end else begin
                want = pending_items.pop_front();
                check_field("item_kind", got.item_kind, want.item_kind);
                check_field("frame_byte", got.frame_byte, want.frame_byte);
                check_field("lower_total", got.lower_total, want.lower_total);
                check_field("upper_total", got.upper_total, want.upper_total);
                check_field("frame_length", got.frame_length, want.frame_length);
                check_field("last_item", got.last_item, want.last_item);
            end
            results_checked++;
        end
    end

    // Stimulus phases
    initial begin : run_phases
        logic [BYTE_W-1:0] sym_a;
        logic [BYTE_W-1:0] sym_b;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table under the reset delimiters
        foreach (DIR_TABLE[i]) begin
            typed_row = (DIR_TABLE[i].chk != CHK_MODEL);
            push_rx(DIR_TABLE[i].rx);
            if (DIR_TABLE[i].chk == CHK_EMPTY) begin
                pending_items.push_back(EMPTY_SUMMARY);
            end
        end
        typed_row = 1'b0;

        // Fill a frame, overflow it with the start symbol so a fresh frame opens,
        // fill that one to the limit and report it; the receiver stalls meanwhile
        hold_armed = 1'b1;
        push_rx(sym_start);
        repeat (MAX_FRAME_LEN_DEF) push_rx(rand_content());
        push_rx(sym_start);
        repeat (MAX_FRAME_LEN_DEF) push_rx(rand_content());
        push_rx(sym_end);

        // Overflow with an ordinary byte: frame dropped, trailing end symbol ignored
        push_rx(sym_start);
        repeat (MAX_FRAME_LEN_DEF) push_rx(rand_content());
        push_rx(UPPER_FIRST + 8'd16);
        push_rx(sym_end);

        send_random_frames(PHASE_ITEMS);
        wait_drained();

        // Extreme delimiters, both ways round; the second pass runs without idling
        set_symbols(8'h00, 8'hFF);
        send_random_frames(PHASE_ITEMS);
        wait_drained();

        no_idle = 1'b1;
        set_symbols(8'hFF, 8'h00);
        send_random_frames(PHASE_ITEMS);
        wait_drained();
        no_idle = 1'b0;

        // One byte both opens and closes
        sym_a = BYTE_W'($urandom_range(255));
        set_symbols(sym_a, sym_a);
        send_random_frames(PHASE_ITEMS);
        wait_drained();

        // Random delimiters
        sym_a = BYTE_W'($urandom_range(255));
        sym_b = BYTE_W'($urandom_range(255));
        set_symbols(sym_a, sym_b);
        send_random_frames(PHASE_ITEMS);
        wait_drained();

        $display("fed %0d frame bytes under five delimiter settings, checked %0d results",
                 bytes_fed, results_checked);
        $display("%0d frames reported, %0d dropped on overflow, %0d long output stalls",
                 frames_reported, frames_dropped, holds_done);
        if (mismatches == 0 && pending_items.size() == 0) begin
            $display("PASS delimited_frame_letter_counter_top");
        end else begin
            $display("FAIL delimited_frame_letter_counter_top");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("FAIL delimited_frame_letter_counter_top");
        $finish;
    end

endmodule
